[sv/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, constants and class-geometry functions for the size class
// bitmap allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int CLASS_COUNT_DEF = 14;
  localparam int MAX_SLOTS_DEF   = 8192;
  localparam logic [31:0] POOL_BASE_RESET = 32'd104857600;
  localparam int WORD_W  = 64;
  localparam int WORD_AW = 6;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_FULL         = 3'd2,
    ST_BELOW        = 3'd3,
    ST_BEYOND       = 3'd4,
    ST_MISALIGNED   = 3'd5,
    ST_ALREADY_FREE = 3'd6
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // slots of class c after the per-class cap
  function automatic logic [13:0] class_slots(input logic [3:0] c, input int max_slots);
    logic [13:0] s;
    case (c)
      4'd9:    s = 14'd4096;
      4'd10:   s = 14'd2048;
      4'd11:   s = 14'd1024;
      4'd12:   s = 14'd512;
      4'd13:   s = 14'd256;
      default: s = 14'd8192;
    endcase
    if (int'(s) > max_slots) s = 14'(max_slots);
    return s;
  endfunction

  function automatic logic [27:0] region_bytes(input logic [3:0] c, input int max_slots);
    return 28'(class_slots(c, max_slots)) << c;
  endfunction

  function automatic logic [27:0] region_start(input logic [3:0] c, input int max_slots);
    logic [27:0] acc;
    acc = '0;
    for (int i = 0; i < 14; i++)
      if (4'(i) < c) acc = acc + region_bytes(4'(i), max_slots);
    return acc;
  endfunction

endpackage

[sv/size_class_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator
// Power-of-two size class allocator, bitmaps in one 64-bit-wide memory.
// Alloc: decode, then scan the class's bitmap words in turn (read, check)
// until a free bit is found, then write the set bit and output the grant.
// Free: decode, read, check, write, output.
// After reset a clearing pass zeroes every memory word (1792 by default);
// no item is accepted meanwhile.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator
  import scba_pkg::*;
#(
  parameter int CLASS_COUNT         = CLASS_COUNT_DEF,
  parameter int MAX_SLOTS_PER_CLASS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // opcode[0], request_size[16:1], block_address[48:17]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // granted_address[31:0], status[34:32]
);

  localparam int WPC  = (MAX_SLOTS_PER_CLASS + WORD_W - 1) / WORD_W;
  localparam int WPCW = $clog2(WPC) < 1 ? 1 : $clog2(WPC);
  localparam int DEPTH = CLASS_COUNT * (1 << WPCW);
  localparam int AW   = $clog2(DEPTH) < 1 ? 1 : $clog2(DEPTH);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DEC   = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_WR    = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_FCHK  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [AW-1:0]     clr_r;
  logic [31:0]       base_r;
  logic              op_r;
  logic [15:0]       size_r;
  logic [31:0]       addr_r;
  logic [3:0]        cls_r;
  logic [WPCW-1:0]   word_r;
  logic [WPCW:0]     nwords_r;
  logic [WORD_AW-1:0] bit_r;
  logic [WORD_W-1:0] wdata_r;
  logic [31:0]       gaddr_r;
  status_t           st_r;
  logic              ovalid_r;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     cur_addr;

  assign cur_addr  = AW'({cls_r, word_r} & {4'hf, {WPCW{1'b1}}});
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, st_r, gaddr_r};

  // ceiling log2 of the size, 16 when too large
  function automatic logic [4:0] ceil_log2(input logic [15:0] s);
    logic [4:0] n;
    n = 5'd16;
    for (int k = 15; k >= 0; k--)
      if ((17'd1 << k) >= 17'(s)) n = 5'(k);
    return n;
  endfunction

  // lowest free bit
  logic [WORD_W-1:0] inv;
  logic [WORD_AW-1:0] low_idx;
  logic               any_free;
  always_comb begin
    inv = ~rdata_r;
    low_idx = '0;
    for (int k = WORD_W - 1; k >= 0; k--)
      if (inv[k]) low_idx = WORD_AW'(k);
    any_free = |inv;
  end

  // free decode
  logic [31:0] off;
  logic [3:0]  fcls;
  logic        fhit;
  logic [27:0] foff;
  always_comb begin
    off = addr_r - base_r;
    fcls = '0; fhit = 1'b0; foff = '0;
    for (int c = 0; c < 14; c++) begin
      if (c < CLASS_COUNT && !fhit &&
          {4'd0, off} < 36'(region_start(4'(c), MAX_SLOTS_PER_CLASS)) +
                        36'(region_bytes(4'(c), MAX_SLOTS_PER_CLASS))) begin
        fhit = 1'b1;
        fcls = 4'(c);
        foff = off[27:0] - region_start(4'(c), MAX_SLOTS_PER_CLASS);
      end
    end
  end

  logic [4:0]  cl2;
  logic [13:0] fslot;
  logic        bad_size;
  logic        misal;
  logic        free_rej;
  logic        last_word;
  assign cl2 = ceil_log2(size_r);
  assign fslot = 14'(foff >> fcls);
  assign bad_size = (size_r == 16'd0) || (32'(cl2) >= 32'(CLASS_COUNT));
  assign misal = (foff & ((28'd1 << fcls) - 28'd1)) != '0;
  assign free_rej = (addr_r < base_r) || !fhit || misal;
  assign last_word = (WPCW+1)'(word_r) + 1'b1 >= nwords_r;

  always_comb begin
    state_nxt = state_r;
    we = 1'b0; waddr = cur_addr; wdata = wdata_r; raddr = cur_addr;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r; wdata = '0;
        if (32'(clr_r) == 32'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE:  if (in_tvalid && in_tready) state_nxt = S_DEC;
      S_DEC: begin
        if (op_r == OP_ALLOC) state_nxt = bad_size ? S_OUT : S_RD;
        else state_nxt = free_rej ? S_OUT : S_RD;
      end
      S_RD:    state_nxt = (op_r == OP_FREE) ? S_FCHK : S_CHK;
      S_CHK: begin
        if (any_free) state_nxt = S_WR;
        else if (last_word) state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_FCHK:  state_nxt = rdata_r[bit_r] ? S_WR : S_OUT;
      S_WR: begin
        we = 1'b1; state_nxt = S_OUT;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; base_r <= POOL_BASE_RESET; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) base_r <= cfg_data;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r <= in_tdata[0]; size_r <= in_tdata[16:1]; addr_r <= in_tdata[48:17];
        end
        S_DEC: begin
          gaddr_r <= '0;
          if (op_r == OP_ALLOC) begin
            cls_r <= cl2[3:0];
            word_r <= '0;
            nwords_r <= (WPCW+1)'((32'(class_slots(cl2[3:0], MAX_SLOTS_PER_CLASS)) +
                        WORD_W - 1) / WORD_W);
            if (bad_size) st_r <= ST_BAD_SIZE;
          end else begin
            cls_r <= fcls;
            word_r <= WPCW'(fslot >> WORD_AW);
            bit_r <= fslot[WORD_AW-1:0];
            if (addr_r < base_r) st_r <= ST_BELOW;
            else if (!fhit) st_r <= ST_BEYOND;
            else if (misal) st_r <= ST_MISALIGNED;
          end
        end
        S_CHK: begin
          if (any_free) begin
            bit_r <= low_idx;
            wdata_r <= rdata_r | (WORD_W'(1) << low_idx);
            st_r <= ST_OK;
            gaddr_r <= base_r + 32'(region_start(cls_r, MAX_SLOTS_PER_CLASS)) +
                       (32'({word_r, low_idx}) << cls_r);
          end else if (last_word) st_r <= ST_FULL;
          else word_r <= word_r + 1'b1;
        end
        S_FCHK: begin
          if (!rdata_r[bit_r]) st_r <= ST_ALREADY_FREE;
          else begin
            st_r <= ST_OK;
            wdata_r <= rdata_r & ~(WORD_W'(1) << bit_r);
          end
        end
        S_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_ok_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && op_r == OP_FREE) |-> (gaddr_r == 32'd0)) else $error("free addr");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st_r != ST_OK) |-> (gaddr_r == 32'd0)) else $error("fail addr");

endmodule

[test/size_class_bitmap_allocator_chk.sv]
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_chk
// Watches the config, request and grant channels of the allocator, keeps its
// own slot bitmaps and pool base, predicts each grant and compares it.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator_chk
  import scba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          grants_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] addr;
    status_t     st;
  } grant_t;

  bit          slot_map [14][8192];
  logic [31:0] base_addr;
  grant_t      grant_q [$];

  function automatic longint class_slots_of(int c);
    return (c <= 8) ? 8192 : (8192 >> (c - 8));
  endfunction

  function automatic longint class_offset(int c);
    longint acc;
    acc = 0;
    for (int i = 0; i < c; i++) acc += class_slots_of(i) << i;
    return acc;
  endfunction

  function automatic grant_t model_alloc(logic [15:0] sz);
    grant_t g;
    int n;
    g.addr = '0;
    g.st   = ST_FULL;
    n = 0;
    while (n < 16 && (32'd1 << n) < sz) n++;
    if (sz == 0 || n >= 14) begin
      g.st = ST_BAD_SIZE;
      return g;
    end
    for (int i = 0; i < class_slots_of(n); i++) begin
      if (!slot_map[n][i]) begin
        slot_map[n][i] = 1'b1;
        g.addr = 32'(longint'(base_addr) + class_offset(n) + (longint'(i) << n));
        g.st   = ST_OK;
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t model_free(logic [31:0] a);
    grant_t g;
    longint off, rb;
    int c;
    g.addr = '0;
    if (a < base_addr) begin
      g.st = ST_BELOW;
      return g;
    end
    off = longint'(a - base_addr);
    for (c = 0; c < 14; c++) begin
      rb = class_slots_of(c) << c;
      if (off < rb) break;
      off -= rb;
    end
    if (c >= 14) g.st = ST_BEYOND;
    else if ((off & ((longint'(1) << c) - 1)) != 0) g.st = ST_MISALIGNED;
    else if (!slot_map[c][off >> c]) g.st = ST_ALREADY_FREE;
    else begin
      slot_map[c][off >> c] = 1'b0;
      g.st = ST_OK;
    end
    return g;
  endfunction

  initial begin
    fail_count = 0;
    grants_due = 0;
    base_addr  = POOL_BASE_RESET;
  end

  always @(posedge clk) begin
    grant_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) base_addr = cfg_data;
      if (in_tvalid && in_tready)
        grant_q.push_back(in_tdata[0] == OP_ALLOC ? model_alloc(in_tdata[16:1])
                                                   : model_free(in_tdata[48:17]));
      if (out_tvalid && out_tready) begin
        got.addr = out_tdata[31:0];
        got.st   = status_t'(out_tdata[34:32]);
        if (grant_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected item: addr %h status %0d", got.addr, got.st);
        end else begin
          want = grant_q.pop_front();
          if (got.addr !== want.addr || got.st !== want.st) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       want.addr, want.st, got.addr, got.st);
          end
        end
      end
      grants_due = grant_q.size();
    end
  end

endmodule

[test/size_class_bitmap_allocator_tb.sv]
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_tb
// Drives alloc and free requests and pool base changes into the allocator,
// with random gaps and back-pressure; the checker judges every grant.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator_tb;
  import scba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count, grants_due;

  bit          gaps_on = 1'b1;
  int          hold_cycles = 0;
  longint      cycles = 0;
  logic [31:0] live_blocks [$];
  bit          sent_ops [$];

  size_class_bitmap_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  size_class_bitmap_allocator_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .grants_due(grants_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver with random stalls and the occasional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (!gaps_on) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 36);
  end

  // track granted blocks so frees can target live ones
  always @(posedge clk) begin
    bit op;
    if (rst_n) begin
      if (in_tvalid && in_tready) sent_ops.push_back(in_tdata[0]);
      if (out_tvalid && out_tready && sent_ops.size() > 0) begin
        op = sent_ops.pop_front();
        if (op == OP_ALLOC && out_tdata[34:32] == ST_OK) live_blocks.push_back(out_tdata[31:0]);
      end
    end
  end

  task automatic send_item(bit op, logic [15:0] sz, logic [31:0] a);
    if (gaps_on && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, a, sz, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grants_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_base(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic alloc_rand;
    int k;
    logic [15:0] sz;
    case ($urandom_range(19))
      0:       sz = 16'd0;
      1:       sz = 16'($urandom_range(8193, 65535));
      2:       sz = 16'($urandom);
      default: begin
        k  = $urandom_range(0, 13);
        sz = (k == 0) ? 16'd1 : 16'($urandom_range((1 << k) / 2 + 1, 1 << k));
      end
    endcase
    send_item(OP_ALLOC, sz, $urandom);
  endtask

  task automatic free_rand;
    int idx;
    logic [31:0] a;
    if (live_blocks.size() > 0 && $urandom_range(9) < 8) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[idx];
      live_blocks.delete(idx);
      case ($urandom_range(9))
        0:       a = a + 1;
        1:       live_blocks.push_back(a);
        default: ;
      endcase
    end else a = $urandom;
    send_item(OP_FREE, 16'($urandom), a);
  endtask

  task automatic random_run(int count);
    repeat (count) begin
      if ($urandom_range(99) < 55) alloc_rand();
      else free_rand();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(OP_ALLOC, 16'd1, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 16'd2, '0);
    send_item(OP_ALLOC, 16'd3, '0);
    send_item(OP_ALLOC, 16'd4096, '0);
    send_item(OP_ALLOC, 16'd4097, '0);
    send_item(OP_ALLOC, 16'd8192, '0);
    send_item(OP_ALLOC, 16'd8193, '0);
    send_item(OP_ALLOC, 16'd0, '0);
    send_item(OP_ALLOC, 16'hFFFF, '0);
    send_item(OP_FREE, 16'hFFFF, POOL_BASE_RESET);
    send_item(OP_FREE, 16'd0, POOL_BASE_RESET);
    send_item(OP_FREE, 16'd0, POOL_BASE_RESET - 1);
    send_item(OP_FREE, 16'd0, POOL_BASE_RESET + 32'd14671872);
    send_item(OP_FREE, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_FREE, 16'd0, '0);
    send_item(OP_FREE, 16'd0, POOL_BASE_RESET + 32'd8193);
    send_item(OP_FREE, 16'd0, POOL_BASE_RESET + 32'd8192);
    drain();

    random_run(300);
    drain();
    live_blocks.delete();

    // top of the address space: grants wrap past zero
    set_base(32'hFFFF_FFFF);
    repeat (4) send_item(OP_ALLOC, 16'd1, '0);
    send_item(OP_FREE, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_FREE, 16'd0, 32'h0000_0000);
    drain();
    set_base(32'hFFF0_0000);
    gaps_on = 1'b0;
    repeat (262) send_item(OP_ALLOC, 16'($urandom_range(4097, 8192)), '0);
    gaps_on = 1'b1;
    random_run(60);
    drain();
    live_blocks.delete();

    set_base(32'h0000_0000);
    hold_cycles = 600;
    random_run(250);
    drain();

    set_base(POOL_BASE_RESET);
    hold_cycles = 400;
    random_run(300);
    drain();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[size_class_bitmap_allocator.f]
sv/scba_pkg.sv
sv/size_class_bitmap_allocator.sv
test/size_class_bitmap_allocator_chk.sv
test/size_class_bitmap_allocator_tb.sv
